### sv/dim_pkg.sv
// shared types, widths and table-building functions for the dilepton mass block
package dim_pkg;

    localparam int COUNT_W = 8;
    localparam int PT_W    = 13;
    localparam int ANGLE_W = 12;
    localparam int MASS_W  = 16;

    localparam logic [COUNT_W-1:0] MIN_OBJECTS = 8'd2;

    // table value widths (q30)
    localparam int COS_W  = 32;
    localparam int COSH_W = 53;

    // product path widths
    localparam int PP_W   = 2 * PT_W;
    localparam int P_W    = PP_W + 1;
    localparam int D_W    = 53;
    localparam int DL_W   = 27;
    localparam int DH_W   = D_W - DL_W;
    localparam int MLO_W  = P_W + DL_W;
    localparam int MHI_W  = P_W + DH_W;
    localparam int FULL_W = MHI_W + DL_W + 1;
    localparam int SQ_SHIFT = 14;
    localparam int S_W    = 64 - SQ_SHIFT;

    // square root pipeline
    localparam int SQ_IN_W            = 56;
    localparam int SQ_ROOT_W          = SQ_IN_W / 2;
    localparam int SQ_REM_W           = SQ_ROOT_W + 2;
    localparam int SQ_STEPS_PER_STAGE = 4;
    localparam int SQ_STAGES          = SQ_ROOT_W / SQ_STEPS_PER_STAGE;
    localparam int ROUND_HALF         = 128;
    localparam int ROUND_SHIFT        = 8;

    localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;
    localparam logic [63:0] LOW32     = 64'hFFFF_FFFF;
    localparam logic [63:0] PI_Q40    = 64'h3243F6A8886;
    localparam logic [63:0] E_Q32     = 64'h2B7E15163;
    localparam logic [63:0] INV_E_Q32 = 64'h5E2D58D9;

    typedef struct packed {
        logic [COUNT_W-1:0]        object_count;
        logic [PT_W-1:0]           pt_a;
        logic signed [ANGLE_W-1:0] eta_a;
        logic signed [ANGLE_W-1:0] phi_a;
        logic [PT_W-1:0]           pt_b;
        logic signed [ANGLE_W-1:0] eta_b;
        logic signed [ANGLE_W-1:0] phi_b;
    } dim_in_t;

    typedef struct packed {
        logic [MASS_W-1:0] mass;
        logic              mass_valid;
        logic              mass_saturated;
    } dim_out_t;

    typedef struct packed {
        logic ok;
        logic sat;
    } dim_side_t;

    // q32 multiply, upper product bits kept modulo 2^64
    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl;
        ah = a >> 32;
        al = a & LOW32;
        bh = b >> 32;
        bl = b & LOW32;
        return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
    endfunction

    function automatic logic [63:0] div_cos(input logic [63:0] v, input int n);
        logic [63:0] q;
        case (n)
            1: q = v / 64'd2;
            2: q = v / 64'd12;
            3: q = v / 64'd30;
            4: q = v / 64'd56;
            5: q = v / 64'd90;
            6: q = v / 64'd132;
            7: q = v / 64'd182;
            8: q = v / 64'd240;
            default: q = v;
        endcase
        return q;
    endfunction

    function automatic logic [63:0] div_sin(input logic [63:0] v, input int n);
        logic [63:0] q;
        case (n)
            1: q = v / 64'd6;
            2: q = v / 64'd20;
            3: q = v / 64'd42;
            4: q = v / 64'd72;
            5: q = v / 64'd110;
            6: q = v / 64'd156;
            7: q = v / 64'd210;
            8: q = v / 64'd272;
            default: q = v;
        endcase
        return q;
    endfunction

    function automatic logic [63:0] div_fact(input logic [63:0] v, input int n);
        logic [63:0] q;
        case (n)
            1: q = v;
            2: q = v / 64'd2;
            3: q = v / 64'd3;
            4: q = v / 64'd4;
            5: q = v / 64'd5;
            6: q = v / 64'd6;
            7: q = v / 64'd7;
            8: q = v / 64'd8;
            9: q = v / 64'd9;
            10: q = v / 64'd10;
            11: q = v / 64'd11;
            12: q = v / 64'd12;
            default: q = v;
        endcase
        return q;
    endfunction

    // cos(x), x in q32 within the first octant
    function automatic logic [63:0] cos_series(input logic [63:0] x);
        logic [63:0] x2, term;
        logic signed [63:0] sum;
        x2 = mulq(x, x);
        term = ONE_Q32;
        sum = $signed(ONE_Q32);
        for (int n = 1; n <= 8; n++)
        begin
            term = div_cos(mulq(term, x2), n);
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        return (sum < 0) ? 64'd0 : sum;
    endfunction

    // sin(x), x in q32 within the first octant
    function automatic logic [63:0] sin_series(input logic [63:0] x);
        logic [63:0] x2, term;
        logic signed [63:0] sum;
        x2 = mulq(x, x);
        term = x;
        sum = $signed(x);
        for (int n = 1; n <= 8; n++)
        begin
            term = div_sin(mulq(term, x2), n);
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        return (sum < 0) ? 64'd0 : sum;
    endfunction

    function automatic logic [63:0] turn_angle(input logic [63:0] k, input int tb);
        logic [63:0] p;
        p = k * PI_Q40;
        return (p + (64'd1 << (6 + tb))) >> (7 + tb);
    endfunction

    // cos table entry k of a 2^tb entry full-turn table, q30 signed
    function automatic logic signed [COS_W-1:0] cos_entry(input logic [63:0] k_in,
                                                          input int tb);
        logic [63:0] n, k, v;
        logic neg;
        logic signed [COS_W-1:0] ret;
        n = 64'd1 << tb;
        k = k_in & (n - 64'd1);
        neg = 1'b0;
        if (k > (n >> 1))
            k = n - k;
        if (k > (n >> 2))
        begin
            k = (n >> 1) - k;
            neg = 1'b1;
        end
        if (k > (n >> 3))
            v = sin_series(turn_angle((n >> 2) - k, tb));
        else
            v = cos_series(turn_angle(k, tb));
        v = (v + 64'd2) >> 2;
        ret = COS_W'(v);
        if (neg)
            ret = -ret;
        return ret;
    endfunction

    // cosh(m/256) in q30
    function automatic logic [COSH_W-1:0] cosh_entry(input logic [63:0] m);
        logic [63:0] f, term, pos, pw, nw, cnt, sum;
        logic signed [63:0] negs;
        f = (m & 64'd255) << 24;
        term = ONE_Q32;
        pos = ONE_Q32;
        pw = ONE_Q32;
        nw = ONE_Q32;
        negs = $signed(ONE_Q32);
        for (int n = 1; n <= 12; n++)
        begin
            term = div_fact(mulq(term, f), n);
            pos = pos + term;
            if (n % 2 == 1)
                negs = negs - $signed(term);
            else
                negs = negs + $signed(term);
        end
        if (negs < 0)
            negs = 64'sd0;
        cnt = (m >> 8) & 64'd15;
        for (int i = 0; i < 15; i++)
        begin
            if (64'(i) < cnt)
            begin
                pw = mulq(pw, E_Q32);
                nw = mulq(nw, INV_E_Q32);
            end
        end
        pos = mulq(pw, pos);
        sum = (pos + mulq(nw, negs) + 64'd4) >> 3;
        return sum[COSH_W-1:0];
    endfunction

endpackage

### sv/dim_stream_if.sv
// valid/ready stream channel carrying one payload struct
interface dim_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/dim_trig_rom.sv
// cos and cosh constant tables with registered read
module dim_trig_rom
    import dim_pkg::*;
#(
    parameter int TRIG_TABLE_BITS = 10,
    parameter int COSH_TABLE_BITS = 11
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [TRIG_TABLE_BITS-1:0]  cos_idx,
    input  logic [COSH_TABLE_BITS-1:0]  cosh_idx,
    output logic signed [COS_W-1:0]     cos_val,
    output logic [COSH_W-1:0]           cosh_val
);
    localparam int COS_N  = 1 << TRIG_TABLE_BITS;
    localparam int COSH_N = 1 << COSH_TABLE_BITS;
    localparam int CS     = ANGLE_W - COSH_TABLE_BITS;

    logic signed [COS_W-1:0] cos_tab [COS_N];
    logic [COSH_W-1:0]       cosh_tab [COSH_N];
    logic signed [COS_W-1:0] cos_reg;
    logic [COSH_W-1:0]       cosh_reg;

    for (genvar g = 0; g < COS_N; g++)
    begin : g_cos
        localparam logic signed [COS_W-1:0] ENTRY = cos_entry(64'(g), TRIG_TABLE_BITS);
        assign cos_tab[g] = ENTRY;
    end

    // entry j holds cosh at |deta| = j steps of the table pitch
    for (genvar g = 0; g < COSH_N; g++)
    begin : g_cosh
        localparam logic [COSH_W-1:0] ENTRY = cosh_entry(64'(g) << CS);
        assign cosh_tab[g] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg  <= cos_tab[cos_idx];
            cosh_reg <= cosh_tab[cosh_idx];
        end
    end

    assign cos_val  = cos_reg;
    assign cosh_val = cosh_reg;
endmodule

### sv/dim_isqrt.sv
// pipelined restoring integer square root, four root bits per stage
module dim_isqrt
    import dim_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  dim_side_t             in_side,
    input  logic [SQ_IN_W-1:0]    radicand,
    output logic                  out_valid,
    output dim_side_t             out_side,
    output logic [SQ_ROOT_W-1:0]  root
);
    logic [SQ_STAGES-1:0]  valid_reg;
    dim_side_t             side_reg [SQ_STAGES];
    logic [SQ_IN_W-1:0]    rad_reg  [SQ_STAGES];
    logic [SQ_REM_W-1:0]   rem_reg  [SQ_STAGES];
    logic [SQ_ROOT_W-1:0]  root_reg [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_stage
        logic                 valid_in;
        dim_side_t            side_in;
        logic [SQ_IN_W-1:0]   rad_in, rad_next;
        logic [SQ_REM_W-1:0]  rem_in, rem_next;
        logic [SQ_ROOT_W-1:0] root_in, root_next;

        if (s == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign side_in  = in_side;
            assign rad_in   = radicand;
            assign rem_in   = '0;
            assign root_in  = '0;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[s-1];
            assign side_in  = side_reg[s-1];
            assign rad_in   = rad_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign root_in  = root_reg[s-1];
        end

        // bring down two radicand bits, try root*4+1
        always_comb
        begin
            rad_next  = rad_in;
            rem_next  = rem_in;
            root_next = root_in;
            for (int k = 0; k < SQ_STEPS_PER_STAGE; k++)
            begin
                rem_next = {rem_next[SQ_REM_W-3:0], rad_next[SQ_IN_W-1 -: 2]};
                rad_next = {rad_next[SQ_IN_W-3:0], 2'b00};
                if (rem_next >= {root_next, 2'b01})
                begin
                    rem_next  = rem_next - {root_next, 2'b01};
                    root_next = {root_next[SQ_ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    root_next = {root_next[SQ_ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s] <= side_in;
                rad_reg[s]  <= rad_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign out_valid = valid_reg[SQ_STAGES-1];
    assign out_side  = side_reg[SQ_STAGES-1];
    assign root      = root_reg[SQ_STAGES-1];
endmodule

### sv/dilepton_invariant_mass.sv
// dilepton invariant mass top level: angle deltas, table lookups, product and square root
// throughput: one request per cycle while the skid entry is empty; stages: index, table read,
//   difference, multiply, sum, seven square root stages, final rounding, then an output register
//   with a skid entry
// reset: rst_n clears all valid bits and the output buffer, payload registers are not reset
module dilepton_invariant_mass
    import dim_pkg::*;
#(
    parameter int TRIG_TABLE_BITS = 10,
    parameter int COSH_TABLE_BITS = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    dim_stream_if.sink   pair,
    dim_stream_if.source result
);
    // table index rounding: drop the low angle bits with round half up
    localparam int TS = ANGLE_W - TRIG_TABLE_BITS;
    localparam int CS = ANGLE_W - COSH_TABLE_BITS;
    localparam logic [ANGLE_W:0] TS_HALF = (ANGLE_W + 1)'((1 << TS) >> 1);
    localparam logic [ANGLE_W:0] CS_HALF = (ANGLE_W + 1)'((1 << CS) >> 1);

    // whole pipeline moves together; it stalls only while the skid entry is full
    logic pipe_en;
    logic push;

    // stage 0: index math and pt product
    logic [ANGLE_W-1:0]         dphi;
    logic [ANGLE_W:0]           ci_sum;
    logic signed [ANGLE_W:0]    deta;
    logic [ANGLE_W-1:0]         adeta;
    logic [ANGLE_W:0]           hj_sum;
    logic [COSH_TABLE_BITS:0]   hj_wide;
    logic [TRIG_TABLE_BITS-1:0] ci_next;
    logic [COSH_TABLE_BITS-1:0] hj_next;
    logic [PP_W-1:0]            pp_next;

    logic                       s1_valid_reg, s1_ok_reg;
    logic [TRIG_TABLE_BITS-1:0] s1_ci_reg;
    logic [COSH_TABLE_BITS-1:0] s1_hj_reg;
    logic [PP_W-1:0]            s1_pp_reg;

    // stage 2: table read
    logic signed [COS_W-1:0] cos_val;
    logic [COSH_W-1:0]       cosh_val;
    logic                    s2_valid_reg, s2_ok_reg;
    logic [PP_W-1:0]         s2_pp_reg;

    // stage 3: cosh - cos clamped at zero
    logic signed [COSH_W+1:0] diff;
    logic [D_W-1:0]           d_next;
    logic                     s3_valid_reg, s3_ok_reg;
    logic [D_W-1:0]           s3_d_reg;
    logic [P_W-1:0]           s3_p_reg;

    // stage 4: split multiply
    logic [MLO_W-1:0] m_lo_next;
    logic [MHI_W-1:0] m_hi_next;
    logic             s4_valid_reg, s4_ok_reg;
    logic [MLO_W-1:0] s4_m_lo_reg;
    logic [MHI_W-1:0] s4_m_hi_reg;

    // stage 5: recombine, overflow check, mass^2 in q16
    logic [FULL_W-1:0] full;
    logic              s5_valid_reg;
    dim_side_t         s5_side_reg;
    logic [S_W-1:0]    s5_sq_reg;

    // square root and final rounding
    logic                  sq_valid;
    dim_side_t             sq_side;
    logic [SQ_ROOT_W-1:0]  sq_root;
    logic [SQ_ROOT_W:0]    rounded;
    logic [SQ_ROOT_W-ROUND_SHIFT:0] mass_wide;
    logic                  too_big;
    dim_out_t              fin_next;
    logic                  fin_valid_reg;
    dim_out_t              fin_data_reg;

    // output register plus skid entry
    logic     out_valid_reg, skid_valid_reg;
    dim_out_t out_data_reg, skid_data_reg;

    assign pipe_en    = !skid_valid_reg;
    assign pair.ready = pipe_en;
    assign push       = fin_valid_reg && pipe_en;

    // phi difference wraps modulo one turn
    assign dphi    = pair.data.phi_a - pair.data.phi_b;
    assign ci_sum  = {1'b0, dphi} + TS_HALF;
    assign ci_next = ci_sum[TS +: TRIG_TABLE_BITS];

    assign deta    = {pair.data.eta_a[ANGLE_W-1], pair.data.eta_a}
                   - {pair.data.eta_b[ANGLE_W-1], pair.data.eta_b};
    assign adeta   = deta[ANGLE_W] ? ANGLE_W'(-deta) : deta[ANGLE_W-1:0];
    assign hj_sum  = {1'b0, adeta} + CS_HALF;
    assign hj_wide = hj_sum[CS +: COSH_TABLE_BITS + 1];
    // past the last entry the cosh index clamps
    assign hj_next = hj_wide[COSH_TABLE_BITS] ? '1 : hj_wide[COSH_TABLE_BITS-1:0];

    assign pp_next = PP_W'(pair.data.pt_a) * PP_W'(pair.data.pt_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg  <= pair.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            fin_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_ok_reg   <= (pair.data.object_count >= MIN_OBJECTS);
            s1_ci_reg   <= ci_next;
            s1_hj_reg   <= hj_next;
            s1_pp_reg   <= pp_next;

            s2_ok_reg   <= s1_ok_reg;
            s2_pp_reg   <= s1_pp_reg;

            s3_ok_reg   <= s2_ok_reg;
            s3_d_reg    <= d_next;
            s3_p_reg    <= {s2_pp_reg, 1'b0};

            s4_ok_reg   <= s3_ok_reg;
            s4_m_lo_reg <= m_lo_next;
            s4_m_hi_reg <= m_hi_next;

            s5_side_reg.ok  <= s4_ok_reg;
            s5_side_reg.sat <= |full[FULL_W-1:64];
            s5_sq_reg       <= full[63:SQ_SHIFT];

            fin_data_reg <= fin_next;
        end
    end

    dim_trig_rom #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS),
        .COSH_TABLE_BITS (COSH_TABLE_BITS)
    ) u_rom (
        .clk      (clk),
        .en       (pipe_en),
        .cos_idx  (s1_ci_reg),
        .cosh_idx (s1_hj_reg),
        .cos_val  (cos_val),
        .cosh_val (cosh_val)
    );

    assign diff   = $signed({2'b00, cosh_val}) - (COSH_W + 2)'(cos_val);
    assign d_next = diff[COSH_W+1] ? '0 : diff[D_W-1:0];

    // the 27 x 53 product is cut into two multipliers of at most 27 x 27
    assign m_lo_next = MLO_W'(s3_p_reg) * MLO_W'(s3_d_reg[DL_W-1:0]);
    assign m_hi_next = MHI_W'(s3_p_reg) * MHI_W'(s3_d_reg[D_W-1:DL_W]);

    assign full = {1'b0, s4_m_hi_reg, {DL_W{1'b0}}} + FULL_W'(s4_m_lo_reg);

    dim_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s5_valid_reg),
        .in_side   (s5_side_reg),
        .radicand  (SQ_IN_W'(s5_sq_reg)),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .root      (sq_root)
    );

    // root in 1/256 lsb, round half up to the mass lsb
    assign rounded   = {1'b0, sq_root} + (SQ_ROOT_W + 1)'(ROUND_HALF);
    assign mass_wide = rounded[SQ_ROOT_W:ROUND_SHIFT];
    assign too_big   = |mass_wide[SQ_ROOT_W-ROUND_SHIFT:MASS_W];

    always_comb
    begin
        fin_next.mass_valid     = sq_side.ok;
        fin_next.mass_saturated = sq_side.ok && (sq_side.sat || too_big);
        if (!sq_side.ok)
            fin_next.mass = '0;
        else if (sq_side.sat || too_big)
            fin_next.mass = '1;
        else
            fin_next.mass = mass_wide[MASS_W-1:0];
    end

    // output register; a result arriving while the output waits parks in the skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : fin_data_reg;
        end
        else if (push)
        begin
            skid_data_reg <= fin_data_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.data.mass_valid)
        |-> (result.data.mass == '0 && !result.data.mass_saturated))
        else $error("invalid result carries a nonzero mass or saturation");

    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.mass_saturated) |-> (result.data.mass == '1))
        else $error("saturated result is not full scale");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(fin_valid_reg))
        else $error("final stage changed during a stall");
endmodule

### sim/tb_dilepton_invariant_mass.sv
// testbench for the dilepton invariant mass block: directed and random events against a predictor
`timescale 1ns / 1ps

module tb_dilepton_invariant_mass
    import dim_pkg::*;
();

    // table sizes used by the block under test
    localparam int TRIG_BITS   = 10;
    localparam int COSH_BITS   = 11;
    localparam int TRIG_SHIFT  = 12 - TRIG_BITS;
    localparam int COSH_SHIFT  = 12 - COSH_BITS;
    localparam int TRIG_SIZE   = 1 << TRIG_BITS;
    localparam int COSH_SIZE   = 1 << COSH_BITS;
    localparam int PAIR_MIN    = 2;

    // q32 constants for building the cos and cosh tables
    localparam logic [63:0] UNIT_Q32 = 64'h1_0000_0000;
    localparam logic [63:0] MASK32   = 64'hFFFF_FFFF;
    localparam logic [63:0] PI_Q40_C = 64'h3243F6A8886;
    localparam logic [63:0] E_Q32_C  = 64'h2B7E15163;
    localparam logic [63:0] RE_Q32_C = 64'h5E2D58D9;

    // mass path: squared mass is scaled down before the root, root is rounded half up
    localparam int          MSQ_SHIFT  = 14;
    localparam logic [63:0] RND_HALF   = 64'd128;
    localparam int          RND_SHIFT  = 8;
    localparam logic [63:0] MASS_LIMIT = 64'hFFFF;

    // run control
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;

    logic clk;
    logic rst_n;

    dim_stream_if #(.payload_t(dim_in_t))  pair_if ();
    dim_stream_if #(.payload_t(dim_out_t)) result_if ();

    dilepton_invariant_mass #(
        .TRIG_TABLE_BITS(TRIG_BITS),
        .COSH_TABLE_BITS(COSH_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .pair(pair_if),
        .result(result_if)
    );

    // predicted results, oldest first, one per accepted request
    dim_out_t mass_expect_q[$];
    int       mismatch_count;
    int       cycle_count;

    // idling odds in percent per request / per cycle, zero means a steady stream
    int tx_gap_pct;
    int rx_stall_pct;

    // predictor copies of the two lookup tables, q30
    logic signed [63:0] cos_tab [0:TRIG_SIZE-1];
    logic [63:0]        cosh_tab [0:COSH_SIZE-1];

    // ------------------------------------------------------------------
    // fixed point math of the lookup tables
    // ------------------------------------------------------------------

    // q32 product, high part wraps at 64 bits
    function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl;
        ah = a >> 32;
        al = a & MASK32;
        bh = b >> 32;
        bl = b & MASK32;
        return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
    endfunction

    // taylor cos over the first octant, q32
    function automatic logic [63:0] cos_taylor(input logic [63:0] x);
        logic [63:0]        x2, term;
        logic signed [63:0] acc;
        x2 = q32_mul(x, x);
        term = UNIT_Q32;
        acc = UNIT_Q32;
        for (int n = 1; n <= 8; n++)
        begin
            term = q32_mul(term, x2) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        return (acc < 0) ? 64'd0 : acc;
    endfunction

    // taylor sin over the first octant, q32
    function automatic logic [63:0] sin_taylor(input logic [63:0] x);
        logic [63:0]        x2, term;
        logic signed [63:0] acc;
        x2 = q32_mul(x, x);
        term = x;
        acc = x;
        for (int n = 1; n <= 8; n++)
        begin
            term = q32_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        return (acc < 0) ? 64'd0 : acc;
    endfunction

    // angle of table step k in radians, q32
    function automatic logic [63:0] turn_q32(input logic [63:0] k);
        logic [63:0] p;
        p = k * PI_Q40_C;
        return (p + (64'd1 << (6 + TRIG_BITS))) >> (7 + TRIG_BITS);
    endfunction

    // full turn cos entry, folded onto the first octant, q30
    function automatic logic signed [63:0] cos_q30(input logic [63:0] k_in);
        logic [63:0] n, k, v;
        logic        neg;
        n = 64'd1 << TRIG_BITS;
        k = k_in & (n - 64'd1);
        neg = 1'b0;
        if (k > n / 2)
            k = n - k;
        if (k > n / 4)
        begin
            k = n / 2 - k;
            neg = 1'b1;
        end
        if (k > n / 8)
            v = sin_taylor(turn_q32(n / 4 - k));
        else
            v = cos_taylor(turn_q32(k));
        v = (v + 64'd2) >> 2;
        return neg ? -$signed(v) : $signed(v);
    endfunction

    // cosh(m/256): fractional part by series, integer part by powers of e, q30
    function automatic logic [63:0] cosh_q30(input logic [63:0] m);
        logic [63:0]        f, term, pos, pw, nw;
        logic signed [63:0] neg_sum;
        f = (m & 64'd255) << 24;
        term = UNIT_Q32;
        pos = UNIT_Q32;
        pw = UNIT_Q32;
        nw = UNIT_Q32;
        neg_sum = UNIT_Q32;
        for (int n = 1; n <= 12; n++)
        begin
            term = q32_mul(term, f) / 64'(n);
            pos = pos + term;
            if (n % 2 == 1)
                neg_sum = neg_sum - $signed(term);
            else
                neg_sum = neg_sum + $signed(term);
        end
        if (neg_sum < 0)
            neg_sum = 64'sd0;
        for (int i = 0; i < int'((m >> 8) & 64'd15); i++)
        begin
            pw = q32_mul(pw, E_Q32_C);
            nw = q32_mul(nw, RE_Q32_C);
        end
        pos = q32_mul(pw, pos);
        return (pos + q32_mul(nw, neg_sum) + 64'd4) >> 3;
    endfunction

    // bitwise integer square root, floor
    function automatic logic [63:0] root64(input logic [63:0] v_in);
        logic [63:0] v, res, probe;
        v = v_in;
        res = 64'd0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= res + probe)
            begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end
            else
                res = res >> 1;
            probe = probe >> 2;
        end
        return res;
    endfunction

    task automatic build_tables();
        for (int k = 0; k < TRIG_SIZE; k++)
            cos_tab[k] = cos_q30(64'(k));
        // cosh entry j sits at eta step j << COSH_SHIFT
        for (int j = 0; j < COSH_SIZE; j++)
            cosh_tab[j] = cosh_q30(64'(j) << COSH_SHIFT);
    endtask

    // ------------------------------------------------------------------
    // predictor of one result from one request
    // ------------------------------------------------------------------
    function automatic dim_out_t predict_mass(input dim_in_t ev);
        dim_out_t           r;
        int                 de, a, hj, ci;
        logic [11:0]        dphi;
        logic signed [63:0] diff;
        logic [63:0]        d, p, hi, lo, hs, root, mass_w;
        r = '0;
        // fewer than two objects: no mass at all
        if (int'(ev.object_count) < PAIR_MIN)
            return r;
        r.mass_valid = 1'b1;

        // phi difference wraps modulo a full turn, then rounds onto the cos table
        dphi = ev.phi_a - ev.phi_b;
        ci = ((int'(dphi) + ((1 << TRIG_SHIFT) >> 1)) >> TRIG_SHIFT) & (TRIG_SIZE - 1);

        // eta difference magnitude, rounded onto the cosh table and clamped at its end
        de = int'($signed(ev.eta_a)) - int'($signed(ev.eta_b));
        a = (de < 0) ? -de : de;
        hj = (a + ((1 << COSH_SHIFT) >> 1)) >> COSH_SHIFT;
        if (hj > COSH_SIZE - 1)
            hj = COSH_SIZE - 1;

        diff = $signed(cosh_tab[hj]) - cos_tab[ci];
        d = (diff < 0) ? 64'd0 : diff;

        // 2*pt_a*pt_b*d split at bit 32 so that a 64 bit overflow is caught
        p = 64'(ev.pt_a) * 64'(ev.pt_b) * 64'd2;
        hi = p * (d >> 32);
        lo = p * (d & MASK32);
        if (hi >= UNIT_Q32)
        begin
            r.mass = '1;
            r.mass_saturated = 1'b1;
            return r;
        end
        hs = hi << 32;
        if (lo > ~hs)
        begin
            r.mass = '1;
            r.mass_saturated = 1'b1;
            return r;
        end

        root = root64((hs + lo) >> MSQ_SHIFT);
        mass_w = (root + RND_HALF) >> RND_SHIFT;
        if (mass_w > MASS_LIMIT)
        begin
            r.mass = '1;
            r.mass_saturated = 1'b1;
            return r;
        end
        r.mass = mass_w[MASS_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------
    function automatic dim_in_t make_event(input int cnt, input int pa, input int ea,
                                           input int fa, input int pb, input int eb,
                                           input int fb);
        dim_in_t ev;
        ev.object_count = cnt[COUNT_W-1:0];
        ev.pt_a  = pa[PT_W-1:0];
        ev.eta_a = ea[ANGLE_W-1:0];
        ev.phi_a = fa[ANGLE_W-1:0];
        ev.pt_b  = pb[PT_W-1:0];
        ev.eta_b = eb[ANGLE_W-1:0];
        ev.phi_b = fb[ANGLE_W-1:0];
        return ev;
    endfunction

    // mostly physical momenta, some over the full field and some at the ends
    function automatic int rand_pt();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return 0;
        else if (pick < 10)
            return 8191;
        else if (pick < 40)
            return $urandom_range(0, 8191);
        else
            return $urandom_range(0, 600);
    endfunction

    // mostly inside the detector range, some over the whole 12 bit field
    function automatic int rand_eta();
        if ($urandom_range(0, 99) < 15)
            return int'($urandom_range(0, 4095)) - 2048;
        else
            return int'($urandom_range(0, 2560)) - 1280;
    endfunction

    function automatic dim_in_t rand_event();
        int pick, cnt;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            cnt = $urandom_range(0, 1);
        else if (pick < 13)
            cnt = $urandom_range(0, 255);
        else
            cnt = $urandom_range(2, 12);
        return make_event(cnt, rand_pt(), rand_eta(), $urandom_range(0, 4095),
                          rand_pt(), rand_eta(), $urandom_range(0, 4095));
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: ready with random stall bursts
    // ------------------------------------------------------------------
    initial
    begin : ready_driver
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            result_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        dim_out_t want, got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = result_if.data;
            if (mass_expect_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result with nothing expected: mass %0d valid %0b sat %0b",
                             got.mass, got.mass_valid, got.mass_saturated);
            end
            else
            begin
                want = mass_expect_q.pop_front();
                if (got.mass !== want.mass || got.mass_valid !== want.mass_valid ||
                    got.mass_saturated !== want.mass_saturated)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: mass %0d/%0d valid %0b/%0b sat %0b/%0b (exp/got)",
                                 want.mass, got.mass, want.mass_valid, got.mass_valid,
                                 want.mass_saturated, got.mass_saturated);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one request: optional gap burst, then hold valid until accepted
    task automatic push_event(input dim_in_t ev);
        @(negedge clk);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            pair_if.valid <= 1'b0;
            // payload is noise while valid is low
            pair_if.data <= rand_event();
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        pair_if.valid <= 1'b1;
        pair_if.data <= ev;
        do
            @(posedge clk);
        while (!pair_if.ready);
        mass_expect_q.insert(mass_expect_q.size(), predict_mass(ev));
    endtask

    // drop valid so the held request is not taken twice
    task automatic park_sender();
        @(negedge clk);
        pair_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (mass_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // mass only exists from two objects upward
    task automatic test_object_count_gate();
        push_event(make_event(0, 400, 100, 0, 300, -100, -2048));
        push_event(make_event(1, 400, 100, 0, 300, -100, -2048));
        push_event(make_event(2, 400, 100, 0, 300, -100, -2048));
        push_event(make_event(3, 120, -50, 700, 90, 30, -700));
        push_event(make_event(255, 8191, 0, 1000, 8191, 0, -1000));
    endtask

    // zero momentum, eta ends and beyond, phi wrap and rounding edges
    task automatic test_field_extremes();
        push_event(make_event(2, 0, 0, 0, 8191, 1280, 1000));
        push_event(make_event(2, 8191, -1280, 1000, 0, 0, 0));
        push_event(make_event(2, 0, 0, 0, 0, 0, 0));
        // identical objects: cosh and cos cancel, difference clamps at zero
        push_event(make_event(2, 200, 50, 300, 200, 50, 300));
        push_event(make_event(2, 100, 1280, 0, 100, -1280, 0));
        // eta outside the detector: cosh index clamps at the last entry
        push_event(make_event(2, 40, 2047, 0, 40, -2048, 0));
        push_event(make_event(2, 40, -2048, 5, 40, 2047, 5));
        // phi difference of one step short of a full turn wraps to zero
        push_event(make_event(2, 300, 0, 2047, 300, 0, -2048));
        // back to back in phi
        push_event(make_event(2, 300, 0, 0, 300, 0, -2048));
        // phi difference just below and at the half step of the cos table
        push_event(make_event(2, 500, 0, 1, 500, 0, 0));
        push_event(make_event(2, 500, 0, 2, 500, 0, 0));
        push_event(make_event(2, 8191, 0, 0, 8191, 0, -2048));
    endtask

    // overflow of the product and of the rounded mass, and just inside range
    task automatic test_saturation();
        push_event(make_event(2, 8191, 1280, 0, 8191, -1280, 2047));
        push_event(make_event(2, 8191, 2047, 0, 8191, -2048, 0));
        push_event(make_event(2, 8191, 500, 0, 8191, -500, 0));
        push_event(make_event(2, 8191, 550, 0, 8191, -550, 0));
    endtask

    // sender holds off until the pipeline has emptied, then resumes
    task automatic test_drain_pause();
        for (int i = 0; i < 40; i++)
        begin
            push_event(rand_event());
            if (i == 19)
            begin
                park_sender();
                wait_drained();
            end
        end
    endtask

    // random events in segments with changing idling odds on both sides
    task automatic test_random_events(input int count);
        int mode;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                mode = $urandom_range(0, 3);
                case (mode)
                    0: tx_gap_pct = 0;
                    1: tx_gap_pct = 5;
                    2: tx_gap_pct = 20;
                    default: tx_gap_pct = 50;
                endcase
                mode = $urandom_range(0, 3);
                case (mode)
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 3;
                    2: rx_stall_pct = 10;
                    default: rx_stall_pct = 30;
                endcase
            end
            push_event(rand_event());
        end
    endtask

    // last stretch at full rate on both sides
    task automatic test_steady_stream(input int count);
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        for (int i = 0; i < count; i++)
            push_event(rand_event());
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        pair_if.valid = 1'b0;
        pair_if.data = '0;
        mismatch_count = 0;
        tx_gap_pct = 10;
        rx_stall_pct = 10;
        build_tables();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_object_count_gate();
        test_field_extremes();
        test_saturation();
        test_drain_pause();
        test_random_events(1600);
        test_steady_stream(200);

        // all requests in: drain, then give the pipeline time to show strays
        park_sender();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && mass_expect_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
sv/dim_pkg.sv
sv/dim_stream_if.sv
sv/dim_trig_rom.sv
sv/dim_isqrt.sv
sv/dilepton_invariant_mass.sv
sim/tb_dilepton_invariant_mass.sv
